// ----- design/bc3d_pkg.sv -----
// bc3d_pkg: types, codes and constant tables for the bc3 block decoder
// used by bc3d_texel_pipe and bc3_block_decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bc3d_pkg;

  // compressed block beat, one 128-bit bc3 block
  typedef struct packed {
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [47:0] alpha_codes;
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_codes;
  } bc3d_block_t;

  // decoded texel beat
  typedef struct packed {
    logic [3:0]  texel_index;
    logic [31:0] texel_value;
    logic        last_texel;
  } bc3d_texel_t;

  // one texel handed from the block holder to the pipeline
  typedef struct packed {
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [1:0]  color_code;
    logic [2:0]  alpha_code;
    logic [3:0]  texel_index;
    logic        last_texel;
  } bc3d_issue_t;

  // how the alpha value of a texel is formed
  typedef enum logic [1:0] {
    AK_CONST,
    AK_DIV7,
    AK_DIV5
  } alpha_kind_t;

  // texel byte order codes
  localparam logic [1:0] CO_BGRA = 2'd0;
  localparam logic [1:0] CO_RGBA = 2'd1;
  localparam logic [1:0] CO_ARGB = 2'd2;
  localparam logic [1:0] CO_ABGR = 2'd3;

  // stage 1: widened endpoints and alpha weights
  typedef struct packed {
    logic [7:0]  r0;
    logic [7:0]  r1;
    logic [7:0]  g0;
    logic [7:0]  g1;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [1:0]  color_code;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [2:0]  aw0;
    logic [2:0]  aw1;
    alpha_kind_t akind;
    logic [7:0]  aconst;
    logic [3:0]  texel_index;
    logic        last_texel;
  } bc3d_s1_t;

  // stage 2: weighted sums ahead of the constant divides
  typedef struct packed {
    logic [9:0]  rsum;
    logic [9:0]  gsum;
    logic [9:0]  bsum;
    logic [10:0] asum;
    alpha_kind_t akind;
    logic [7:0]  aconst;
    logic [3:0]  texel_index;
    logic        last_texel;
  } bc3d_s2_t;

  // reciprocal constants: x/3 for x <= 765, x/7 for x <= 1785, x/5 for x <= 1275
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;
  localparam int RECIP7       = 4682;
  localparam int RECIP5       = 6554;
  localparam int RECIPA_SHIFT = 15;

  // endpoint widening tables, round(v*255/31) and round(v*255/63)
  typedef logic [7:0] widen5_tab_t [32];
  typedef logic [7:0] widen6_tab_t [64];

  function automatic widen5_tab_t build_widen5();
    widen5_tab_t tab;
    for (int i = 0; i < 32; i++) begin
      tab[i] = 8'((i * 255 + 15) / 31);
    end
    return tab;
  endfunction

  function automatic widen6_tab_t build_widen6();
    widen6_tab_t tab;
    for (int i = 0; i < 64; i++) begin
      tab[i] = 8'((i * 255 + 31) / 63);
    end
    return tab;
  endfunction

  localparam widen5_tab_t WIDEN5 = build_widen5();
  localparam widen6_tab_t WIDEN6 = build_widen6();

endpackage

`default_nettype wire

// ----- design/bc3d_texel_pipe.sv -----
// bc3d_texel_pipe: three-stage texel decode pipeline with output register
// depends on bc3d_pkg
`timescale 1ns / 1ps
`default_nettype none

module bc3d_texel_pipe (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 issue_valid,
  output logic                      issue_ready,
  input  wire bc3d_pkg::bc3d_issue_t issue,
  input  wire logic [1:0]           channel_order,
  output logic                      texel_valid,
  input  wire logic                 texel_ready,
  output bc3d_pkg::bc3d_texel_t     texel
);
  import bc3d_pkg::*;

  logic        advance;
  logic        s1_valid;
  logic        s2_valid;
  bc3d_s1_t    s1;
  bc3d_s1_t    s1_next;
  bc3d_s2_t    s2;
  bc3d_s2_t    s2_next;
  bc3d_texel_t texel_next;
  logic [19:0] rprod;
  logic [19:0] gprod;
  logic [19:0] bprod;
  logic [22:0] aprod;
  logic [7:0]  rq;
  logic [7:0]  gq;
  logic [7:0]  bq;
  logic [7:0]  aq;
  logic [22:0] arecip;

  // whole pipe moves together unless the output beat is held
  assign advance     = !texel_valid || texel_ready;
  assign issue_ready = advance;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      texel_valid <= 1'b0;
    end else if (advance) begin
      s1_valid    <= issue_valid;
      s2_valid    <= s1_valid;
      texel_valid <= s2_valid;
    end
  end

  // stage 1: widen endpoints, decode alpha code into weights
  always_comb begin
    s1_next.r0 = WIDEN5[issue.color_end0[15:11]];
    s1_next.r1 = WIDEN5[issue.color_end1[15:11]];
    s1_next.g0 = WIDEN6[issue.color_end0[10:5]];
    s1_next.g1 = WIDEN6[issue.color_end1[10:5]];
    s1_next.b0 = WIDEN5[issue.color_end0[4:0]];
    s1_next.b1 = WIDEN5[issue.color_end1[4:0]];
    s1_next.color_code  = issue.color_code;
    s1_next.a0          = issue.alpha_end0;
    s1_next.a1          = issue.alpha_end1;
    s1_next.texel_index = issue.texel_index;
    s1_next.last_texel  = issue.last_texel;
    s1_next.aw0    = 3'd0;
    s1_next.aw1    = 3'd0;
    s1_next.akind  = AK_CONST;
    s1_next.aconst = issue.alpha_end0;
    if (issue.alpha_code == 3'd0) begin
      s1_next.aconst = issue.alpha_end0;
    end else if (issue.alpha_code == 3'd1) begin
      s1_next.aconst = issue.alpha_end1;
    end else if (issue.alpha_end0 > issue.alpha_end1) begin
      // eight-value mode
      s1_next.akind = AK_DIV7;
      s1_next.aw0   = 3'(4'd8 - {1'b0, issue.alpha_code});
      s1_next.aw1   = issue.alpha_code - 3'd1;
    end else if (issue.alpha_code == 3'd6) begin
      s1_next.aconst = 8'd0;
    end else if (issue.alpha_code == 3'd7) begin
      s1_next.aconst = 8'd255;
    end else begin
      // six-value mode
      s1_next.akind = AK_DIV5;
      s1_next.aw0   = 3'd6 - issue.alpha_code;
      s1_next.aw1   = issue.alpha_code - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= s1_next;
    end
  end

  // stage 2: weighted sums, endpoints scaled by three so every code divides by three
  function automatic logic [9:0] color_sum(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [1:0] code);
    logic [9:0] sum;
    case (code)
      2'd0:    sum = 10'({c0, 1'b0}) + 10'(c0);
      2'd1:    sum = 10'({c1, 1'b0}) + 10'(c1);
      2'd2:    sum = 10'({c0, 1'b0}) + 10'(c1);
      default: sum = 10'(c0) + 10'({c1, 1'b0});
    endcase
    return sum;
  endfunction

  always_comb begin
    s2_next.rsum        = color_sum(s1.r0, s1.r1, s1.color_code);
    s2_next.gsum        = color_sum(s1.g0, s1.g1, s1.color_code);
    s2_next.bsum        = color_sum(s1.b0, s1.b1, s1.color_code);
    s2_next.asum        = 11'(s1.aw0) * 11'(s1.a0) + 11'(s1.aw1) * 11'(s1.a1);
    s2_next.akind       = s1.akind;
    s2_next.aconst      = s1.aconst;
    s2_next.texel_index = s1.texel_index;
    s2_next.last_texel  = s1.last_texel;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2 <= s2_next;
    end
  end

  // stage 3: reciprocal divides and byte packing
  always_comb begin
    rprod  = 20'(s2.rsum) * 20'(RECIP3);
    gprod  = 20'(s2.gsum) * 20'(RECIP3);
    bprod  = 20'(s2.bsum) * 20'(RECIP3);
    rq     = rprod[RECIP3_SHIFT+7:RECIP3_SHIFT];
    gq     = gprod[RECIP3_SHIFT+7:RECIP3_SHIFT];
    bq     = bprod[RECIP3_SHIFT+7:RECIP3_SHIFT];
    arecip = (s2.akind == AK_DIV7) ? 23'(RECIP7) : 23'(RECIP5);
    aprod  = 23'(s2.asum) * arecip;
    case (s2.akind) inside
      AK_DIV7, AK_DIV5: aq = aprod[RECIPA_SHIFT+7:RECIPA_SHIFT];
      default:          aq = s2.aconst;
    endcase
    texel_next.texel_index = s2.texel_index;
    texel_next.last_texel  = s2.last_texel;
    unique case (channel_order)
      CO_BGRA: texel_next.texel_value = {aq, rq, gq, bq};
      CO_RGBA: texel_next.texel_value = {aq, bq, gq, rq};
      CO_ARGB: texel_next.texel_value = {bq, gq, rq, aq};
      CO_ABGR: texel_next.texel_value = {rq, gq, bq, aq};
      default: texel_next.texel_value = {aq, rq, gq, bq};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      texel <= texel_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/bc3_block_decoder.sv -----
// bc3_block_decoder: bc3 block to sixteen packed texels, top level
// depends on bc3d_pkg and bc3d_texel_pipe
//
//   channel   signals                        beat
//   blk       blk_valid / blk_ready / blk    one compressed block
//   texel     texel_valid / texel_ready      one decoded texel, index 0..15
//   cfg       cfg_valid / cfg_ready          channel_order, 2 bits
//
// the block holder issues one texel per cycle unless a texel beat is held,
// into a three-stage pipe: stage 1, stage 2 and the output register
// the next block is taken on the cycle the last texel (index 15) issues,
// so blocks run back to back
// rst (synchronous) clears valid bits, the holder and channel_order to BGRA
// a held texel beat stalls the whole pipe and the holder; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module bc3_block_decoder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  blk_valid,
  output logic                       blk_ready,
  input  wire bc3d_pkg::bc3d_block_t blk,
  output logic                       texel_valid,
  input  wire logic                  texel_ready,
  output bc3d_pkg::bc3d_texel_t      texel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_data
);
  import bc3d_pkg::*;

  logic [1:0]  order;
  bc3d_block_t held;
  logic        held_valid;
  logic [3:0]  count;
  logic        issue_ready;
  logic        issue_fire;
  logic        issue_done;
  bc3d_issue_t issue;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= CO_BGRA;
    end else if (cfg_valid && cfg_ready) begin
      order <= cfg_data;
    end
  end

  // block holder and texel counter
  assign issue_fire = held_valid && issue_ready;
  assign issue_done = issue_fire && (count == 4'd15);
  assign blk_ready  = !held_valid || issue_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      count      <= 4'd0;
    end else if (blk_valid && blk_ready) begin
      held_valid <= 1'b1;
      count      <= 4'd0;
    end else if (issue_fire) begin
      held_valid <= !issue_done;
      count      <= count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_ready) begin
      held <= blk;
    end
  end

  // pick this texel's codes out of the held block
  always_comb begin
    issue.alpha_end0  = held.alpha_end0;
    issue.alpha_end1  = held.alpha_end1;
    issue.color_end0  = held.color_end0;
    issue.color_end1  = held.color_end1;
    issue.color_code  = held.color_codes[{count, 1'b0} +: 2];
    issue.alpha_code  = held.alpha_codes[6'(count) * 6'd3 +: 3];
    issue.texel_index = count;
    issue.last_texel  = (count == 4'd15);
  end

  bc3d_texel_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .issue_valid   (held_valid),
    .issue_ready   (issue_ready),
    .issue         (issue),
    .channel_order (order),
    .texel_valid   (texel_valid),
    .texel_ready   (texel_ready),
    .texel         (texel)
  );

  // the counter only leaves zero while a block is held
  assert property (@(posedge clk) disable iff (rst) (count != 4'd0) |-> held_valid)
    else $error("texel counter running with no block held");

  // a new block is never taken in the middle of the current one
  assert property (@(posedge clk) disable iff (rst)
    (held_valid && count != 4'd15) |-> !blk_ready)
    else $error("block accepted while texels remain");

  // the last flag travels with texel fifteen
  assert property (@(posedge clk) disable iff (rst)
    (texel_valid && texel.last_texel) |-> (texel.texel_index == 4'd15))
    else $error("last texel flag on wrong index");

  // the register write lands in the order register
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (order == $past(cfg_data)))
    else $error("channel order write lost");

endmodule

`default_nettype wire
